// File: design/sabs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array binary search package
// Shared sizes, codes, payload types and state encoding for the search block.
// ----------------------------------------------------------------------------
package sabs_pkg;

   // Storage geometry.
   localparam int DEPTH     = 1024;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(DEPTH);

   // Field widths fixed by the interface.
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Command codes.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Register map (byte addresses).
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_COUNT_ADDR = 3'd0;

   // Input item.
   typedef struct packed {
      logic                        command;
      logic [INDEX_W-1:0]          entry_index;
      logic signed [KEY_WIDTH-1:0] value;
   } sabs_req_type;

   // Result item.
   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] position;
   } sabs_rsp_type;

   // Access to the key store from the search engine.
   typedef struct packed {
      logic                 we;
      logic [ADDR_W-1:0]    waddr;
      logic [KEY_WIDTH-1:0] wdata;
      logic [ADDR_W-1:0]    raddr;
   } sabs_mem_req_type;

   // Search sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_REPLY
   } sabs_state_type;

endpackage

// File: design/sabs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sabs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/sabs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary search engine
// Takes load and search items, drives the key store and narrows the search
// window by one probe per cycle, then hands the result to an output register.
// ----------------------------------------------------------------------------
module sabs_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sabs_pkg::sabs_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sabs_pkg::sabs_rsp_type             rsp_data,
   input  logic [sabs_pkg::COUNT_W-1:0]       entry_count,
   output sabs_pkg::sabs_mem_req_type         mem_req,
   input  logic [sabs_pkg::KEY_WIDTH-1:0]     mem_rdata
);
   import sabs_pkg::*;

   sabs_state_type state_ff, state_in;

   logic [ADDR_W-1:0]    low_ff, low_in;
   logic [ADDR_W-1:0]    high_ff, high_in;
   logic [ADDR_W-1:0]    mid_ff, mid_in;
   logic [KEY_WIDTH-1:0] target_ff, target_in;
   logic                 found_ff, found_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sabs_rsp_type         rsp_data_ff, rsp_data_in;

   logic                 req_xfer;
   logic                 is_search;
   logic [COUNT_W-1:0]   count_sat;
   logic [COUNT_W-1:0]   count_less;
   logic [ADDR_W-1:0]    init_high;
   logic                 hit;
   logic                 greater;
   logic                 probe_done;
   logic [ADDR_W-1:0]    next_low;
   logic [ADDR_W-1:0]    next_high;
   logic [ADDR_W:0]      next_sum;
   logic                 slot_free;

   // Items are taken only while the sequencer is idle.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign is_search = (req_data.command == CMD_SEARCH);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Clamp the count to the store depth and derive the first window.
   always_comb begin
      count_sat  = (entry_count > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : entry_count;
      count_less = count_sat - COUNT_W'(1);
      init_high  = count_less[ADDR_W-1:0];
   end

   // Probe compare and window update.
   always_comb begin
      hit        = (mem_rdata == target_ff);
      greater    = ($signed(mem_rdata) > $signed(target_ff));
      probe_done = 1'b0;
      next_low   = low_ff;
      next_high  = high_ff;
      if (hit) begin
         probe_done = 1'b1;
      end else if (greater) begin
         if (mid_ff == low_ff) begin
            probe_done = 1'b1;
         end else begin
            next_high = mid_ff - ADDR_W'(1);
         end
      end else begin
         if (mid_ff == high_ff) begin
            probe_done = 1'b1;
         end else begin
            next_low = mid_ff + ADDR_W'(1);
         end
      end
      next_sum = {1'b0, next_low} + {1'b0, next_high};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && is_search) begin
               state_in = (count_sat == '0) ? ST_REPLY : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory access for each state.
   always_comb begin
      low_in        = low_ff;
      high_in       = high_ff;
      mid_in        = mid_ff;
      target_in     = target_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = req_data.entry_index[ADDR_W-1:0];
      mem_req.wdata = req_data.value;
      mem_req.raddr = mid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && !is_search) begin
               mem_req.we = (32'(req_data.entry_index) < DEPTH);
            end
            if (req_xfer && is_search) begin
               low_in        = '0;
               high_in       = init_high;
               mid_in        = init_high >> 1;
               mem_req.raddr = init_high >> 1;
               target_in     = req_data.value;
               found_in      = 1'b0;
               pos_in        = '0;
            end
         end
         ST_PROBE: begin
            if (hit) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
            end else if (!probe_done) begin
               low_in        = next_low;
               high_in       = next_high;
               mid_in        = next_sum[ADDR_W:1];
               mem_req.raddr = next_sum[ADDR_W:1];
            end
         end
         ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: loaded from the reply state, cleared on transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_REPLY) && slot_free) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.found    = found_ff;
         rsp_data_in.position = INDEX_W'(pos_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      low_ff      <= low_in;
      high_ff     <= high_in;
      mid_ff      <= mid_in;
      target_ff   <= target_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/sorted_array_binary_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array binary search
// Key store with load and search items and a register for the entry count.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries load and search items; a transfer happens when
//   req_valid is high and req_stall is low. A load writes one key into the
//   store in its transfer cycle and gives no result. A search runs a binary
//   search over the first entry_count keys and gives one result on the rsp_
//   channel (found flag and position).
//   Each search probes the key store through its single read port, whose
//   read data is registered. A search passes through the probe and reply
//   states, and the block takes the next item only after the result is
//   loaded into the output register; with an empty array a search goes
//   straight to the reply state. A load leaves the block idle.
//   The result sits in an output register, so a stalled receiver holds only
//   the final reply step; loads are still taken while a result waits.
//   Reset clears the entry count and the control state. The key store is
//   not cleared: only entries that were loaded may be searched.
//   The user must write entry_count through the csr_ port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sorted_array_binary_search_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sabs_pkg::sabs_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sabs_pkg::sabs_rsp_type            rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sabs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sabs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sabs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import sabs_pkg::*;

   logic [COUNT_W-1:0]   entry_count_ff, entry_count_in;
   logic                 csr_write;
   sabs_mem_req_type     mem_req;
   logic [KEY_WIDTH-1:0] mem_rdata;

   // Register port: always ready, write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      entry_count_in = entry_count_ff;
      if (csr_write && (csr_paddr == REG_ENTRY_COUNT_ADDR)) begin
         entry_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Read back the register; other addresses read as zero.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == REG_ENTRY_COUNT_ADDR) begin
         csr_prdata = CSR_DATA_W'(entry_count_ff);
      end
   end

   // Search sequencer.
   sabs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .entry_count (entry_count_ff),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata)
   );

   // Key store.
   sabs_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

endmodule
